/* hdl/pbp_pkg.sv */
package pbp_pkg;

    localparam int PC_W     = 48;
    localparam int WORD_W   = PC_W - 2;
    localparam int SIZE_W   = 4;
    localparam int STAMP_W  = 32;
    localparam int HIST_W   = 10;
    localparam int CNT_W    = 8;
    localparam int WAY_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam logic [3:0] CNT_BITS_MAX  = 4'd8;
    localparam logic [3:0] HIST_BITS_MAX = 4'd10;

    // reset register values and the counter value a cleared table holds
    localparam logic [3:0]       CNT_BITS_RST  = 4'd2;
    localparam logic [3:0]       HIST_BITS_RST = 4'd10;
    localparam logic [CNT_W-1:0] CNT_RESET     = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNTER_BITS = 2'd0,
        REG_HISTORY_BITS = 2'd1,
        REG_INDEX_HASH   = 2'd2,
        REG_NONE         = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        HASH_ADDR     = 2'd0,
        HASH_HIST     = 2'd1,
        HASH_XOR      = 2'd2,
        HASH_XOR_ALT  = 2'd3
    } hash_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } btb_sel_t;

endpackage

/* hdl/pbp_ram.sv */
module pbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/pbp_btb_sel.sv */
module pbp_btb_sel #(
    parameter int WAYS  = 4,
    parameter int TAG_W = 37
) (
    input  logic [WAYS*(TAG_W+pbp_pkg::STAMP_W)-1:0] row,
    input  logic [TAG_W-1:0]                         tag,
    output pbp_pkg::btb_sel_t                        sel
);
    import pbp_pkg::*;

    localparam int EW = TAG_W + STAMP_W;

    logic [STAMP_W-1:0] oldest;
    logic [WAY_W-1:0]   victim;
    logic               hit;
    logic [WAY_W-1:0]   hit_way;

    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        oldest  = '1;
        victim  = '0;
        // first matching way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row[w*EW + STAMP_W +: TAG_W] == tag)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        // oldest stamp, highest way on ties
        for (int w = 0; w < WAYS; w++)
        begin
            if (row[w*EW +: STAMP_W] <= oldest)
            begin
                oldest = row[w*EW +: STAMP_W];
                victim = WAY_W'(w);
            end
        end
        sel.hit = hit;
        sel.way = hit ? hit_way : victim;
    end

endmodule

/* hdl/pas_branch_predictor_btb.sv */
// channel  | direction | handshake            | payload
// request  | in        | start, busy          | pc, instr_size, next_pc, is_branch,
//          |           |                      | cond_branch
// result   | out       | result_valid strobe  | resolve_stage, btb_hit, predicted_taken,
//          |           |                      | actual_taken
// config   | in        | cfg_valid, cfg_ready | cfg_index, cfg_data
// A request is registered on accept, then runs through S_LOOK (BTB row and history
// read, BTB row write, counter read) and S_UPD (counter and history write-back, result
// strobe registered); one request is in flight. After reset a clearing pass over every
// BTB, history and counter entry holds busy high; config writes are taken.
// The result is shown for one cycle; the receiver cannot stall it.
// Table depths must be powers of two; the block itself does not enforce this.
module pas_branch_predictor_btb #(
    parameter int BTB_SETS        = 512,
    parameter int BTB_WAYS        = 4,
    parameter int HISTORY_ENTRIES = 1024,
    parameter int PATTERN_ROWS    = 1024,
    parameter int PATTERN_SETS    = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pbp_pkg::PC_W-1:0]        pc,
    input  logic [pbp_pkg::SIZE_W-1:0]      instr_size,
    input  logic [pbp_pkg::PC_W-1:0]        next_pc,
    input  logic                            is_branch,
    input  logic                            cond_branch,
    output logic                            result_valid,
    output logic                            resolve_stage,
    output logic                            btb_hit,
    output logic                            predicted_taken,
    output logic                            actual_taken,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbp_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import pbp_pkg::*;

    localparam int SET_B  = $clog2(BTB_SETS);
    localparam int SET_AW = BTB_SETS > 1 ? SET_B : 1;
    localparam int TAG_W  = WORD_W - SET_B;
    localparam int EW     = TAG_W + STAMP_W;
    localparam int ROW_W  = BTB_WAYS * EW;
    localparam int HIST_AW = HISTORY_ENTRIES > 1 ? $clog2(HISTORY_ENTRIES) : 1;
    localparam int PAT_DEPTH = PATTERN_ROWS * PATTERN_SETS;
    localparam int PAT_AW  = PAT_DEPTH > 1 ? $clog2(PAT_DEPTH) : 1;
    localparam int CLR_D1  = BTB_SETS > HISTORY_ENTRIES ? BTB_SETS : HISTORY_ENTRIES;
    localparam int CLR_DEPTH = CLR_D1 > PAT_DEPTH ? CLR_D1 : PAT_DEPTH;
    localparam int CLR_W   = $clog2(CLR_DEPTH + 1);
    localparam int KEY_W   = WORD_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_UPD
    } state_t;

    state_t              state_reg;
    logic [CLR_W-1:0]    clr_reg;
    logic [STAMP_W-1:0]  clock_reg;
    logic [3:0]          cnt_bits_reg;
    logic [3:0]          hist_bits_reg;
    hash_t               hash_reg;

    logic [WORD_W-1:0]   word_reg;
    logic                taken_reg;
    logic                br_reg;
    logic                cond_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic                hit_reg;
    logic [HIST_W-1:0]   hist_reg;
    logic [PAT_AW-1:0]   paddr_reg;

    logic [WORD_W-1:0]   in_word;
    logic                in_taken;
    logic                accept;
    logic                clearing;

    logic [ROW_W-1:0]    btb_rdata;
    logic [ROW_W-1:0]    btb_wdata;
    logic                btb_we;
    logic [SET_AW-1:0]   btb_waddr;
    logic [HIST_W-1:0]   hist_rdata;
    logic [HIST_W-1:0]   hist_wdata;
    logic                hist_we;
    logic [HIST_AW-1:0]  hist_waddr;
    logic [CNT_W-1:0]    pat_rdata;
    logic [CNT_W-1:0]    pat_wdata;
    logic                pat_we;
    logic [PAT_AW-1:0]   pat_waddr;
    logic [PAT_AW-1:0]   pat_raddr;

    logic [TAG_W-1:0]    cur_tag;
    btb_sel_t            sel;
    logic [HIST_W-1:0]   hist_mask;
    logic [HIST_W-1:0]   hist_cur;
    logic [KEY_W-1:0]    key;
    logic [3:0]          cb;
    logic [CNT_W:0]      cnt_pow;
    logic [CNT_W-1:0]    cnt_max;
    logic [CNT_W-1:0]    cnt_thr;
    logic                pred;
    logic                late;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && (state_reg == S_IDLE);
    assign clearing  = (state_reg == S_CLEAR);
    assign in_word   = pc[PC_W-1:2];
    assign in_taken  = ({1'b0, pc} + {{(PC_W+1-SIZE_W){1'b0}}, instr_size})
                       != {1'b0, next_pc};

    assign cur_tag = TAG_W'(word_reg >> SET_B);

    pbp_btb_sel #(
        .WAYS  (BTB_WAYS),
        .TAG_W (TAG_W)
    ) u_sel (
        .row (btb_rdata),
        .tag (cur_tag),
        .sel (sel)
    );

    // history and counter index
    always_comb
    begin
        priority if (hist_bits_reg > HIST_BITS_MAX)
            hist_mask = '1;
        else
            hist_mask = HIST_W'((11'd1 << hist_bits_reg) - 11'd1);
        hist_cur = hist_rdata & hist_mask;
        unique case (hash_reg)
            HASH_ADDR:    key = word_reg;
            HASH_HIST:    key = KEY_W'(hist_cur);
            HASH_XOR,
            HASH_XOR_ALT: key = word_reg ^ KEY_W'(hist_cur);
            default:      key = word_reg;
        endcase
        pat_raddr = PAT_AW'(PAT_AW'(key % PATTERN_ROWS) * PATTERN_SETS
                    + PAT_AW'(word_reg % PATTERN_SETS));
    end

    // counter prediction and update
    always_comb
    begin
        cb      = (cnt_bits_reg > CNT_BITS_MAX) ? CNT_BITS_MAX : cnt_bits_reg;
        cnt_pow = (CNT_W+1)'(1) << cb;
        cnt_max = CNT_W'(cnt_pow - (CNT_W+1)'(1));
        cnt_thr = CNT_W'(cnt_pow >> 1);
        pred    = cond_reg ? (pat_rdata >= cnt_thr) : taken_reg;
        pat_wdata = pat_rdata;
        if (taken_reg)
        begin
            if (pat_rdata < cnt_max)
                pat_wdata = pat_rdata + CNT_W'(1);
        end
        else if (pat_rdata != '0)
        begin
            pat_wdata = pat_rdata - CNT_W'(1);
        end
        late = hit_reg ? (cond_reg && (pred != taken_reg)) : taken_reg;
    end

    // write ports
    always_comb
    begin
        btb_wdata = btb_rdata;
        btb_wdata[sel.way*EW +: EW] = {cur_tag, stamp_reg};
        if (clearing)
        begin
            btb_we     = (CLR_W+1)'(clr_reg) < (CLR_W+1)'(BTB_SETS);
            btb_waddr  = SET_AW'(clr_reg);
            btb_wdata  = '0;
            hist_we    = (CLR_W+1)'(clr_reg) < (CLR_W+1)'(HISTORY_ENTRIES);
            hist_waddr = HIST_AW'(clr_reg);
            hist_wdata = '0;
            pat_we     = (CLR_W+1)'(clr_reg) < (CLR_W+1)'(PAT_DEPTH);
            pat_waddr  = PAT_AW'(clr_reg);
        end
        else
        begin
            btb_we     = (state_reg == S_LOOK) && br_reg;
            btb_waddr  = SET_AW'(word_reg % BTB_SETS);
            hist_we    = (state_reg == S_UPD) && br_reg && cond_reg;
            hist_waddr = HIST_AW'(word_reg % HISTORY_ENTRIES);
            hist_wdata = {hist_reg[HIST_W-2:0], taken_reg};
            pat_we     = (state_reg == S_UPD) && br_reg && cond_reg;
            pat_waddr  = paddr_reg;
        end
    end

    pbp_ram #(.WIDTH(ROW_W), .DEPTH(BTB_SETS)) u_btb_ram (
        .clk   (clk),
        .we    (btb_we),
        .waddr (btb_waddr),
        .wdata (clearing ? '0 : btb_wdata),
        .raddr (SET_AW'(in_word % BTB_SETS)),
        .rdata (btb_rdata)
    );

    pbp_ram #(.WIDTH(HIST_W), .DEPTH(HISTORY_ENTRIES)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (HIST_AW'(in_word % HISTORY_ENTRIES)),
        .rdata (hist_rdata)
    );

    pbp_ram #(.WIDTH(CNT_W), .DEPTH(PAT_DEPTH)) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (clearing ? CNT_RESET : pat_wdata),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            clock_reg     <= '0;
            cnt_bits_reg  <= CNT_BITS_RST;
            hist_bits_reg <= HIST_BITS_RST;
            hash_reg      <= HASH_ADDR;
            result_valid  <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_COUNTER_BITS: cnt_bits_reg  <= cfg_data;
                    REG_HISTORY_BITS: hist_bits_reg <= cfg_data;
                    REG_INDEX_HASH:   hash_reg      <= hash_t'(cfg_data[1:0]);
                    REG_NONE:         ;
                    default:          ;
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CLR_W'(1);
                    if (clr_reg == CLR_W'(CLR_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        clock_reg <= clock_reg + STAMP_W'(1);
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    result_valid <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request and stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg  <= in_word;
            taken_reg <= in_taken;
            br_reg    <= is_branch;
            cond_reg  <= cond_branch;
            stamp_reg <= clock_reg;
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg   <= sel.hit;
            hist_reg  <= hist_cur;
            paddr_reg <= pat_raddr;
        end
        if (state_reg == S_UPD)
        begin
            resolve_stage   <= br_reg && late;
            btb_hit         <= br_reg && hit_reg;
            predicted_taken <= br_reg && pred;
            actual_taken    <= br_reg && taken_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_UPD))
        else $error("result strobe without update stage");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !result_valid))
        else $error("accepted request did not hold busy");

    a_miss_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !btb_hit) |-> (resolve_stage == actual_taken))
        else $error("miss resolve stage differs from outcome");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!btb_we && !hist_we && !pat_we))
        else $error("table write while idle");
`endif

endmodule
